// ----- hw/rtl/pdgv_pkg.sv -----
// ----------------------------------------------------------------------------
// pdgv_pkg
// Shared types and constants for the PD grasp velocity controller.
// ----------------------------------------------------------------------------
package pdgv_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam logic [15:0] CONTACT_MASK = 16'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [15:0]        RST_CONTACT_SETPOINT  = 16'd150;
    localparam logic [23:0]        RST_PROP_GAIN         = 24'd4294967;
    localparam logic [23:0]        RST_DERIV_GAIN        = 24'd429497;
    localparam logic [19:0]        RST_VELOCITY_LIMIT    = 20'd104858;
    localparam logic signed [15:0] RST_UPPER_JOINT_LIMIT = 16'sd7700;
    localparam logic signed [15:0] RST_LOWER_JOINT_LIMIT = 16'sd0;

    typedef enum logic [2:0] {
        CFG_CONTACT_SETPOINT  = 3'd0,
        CFG_PROP_GAIN         = 3'd1,
        CFG_DERIV_GAIN        = 3'd2,
        CFG_VELOCITY_LIMIT    = 3'd3,
        CFG_UPPER_JOINT_LIMIT = 3'd4,
        CFG_LOWER_JOINT_LIMIT = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_JOINT   = 2'd1,
        FAULT_CONTACT = 2'd2
    } fault_t;

    typedef struct packed {
        logic [15:0]        touch_area;
        logic               contact_fresh;
        logic signed [15:0] joint_position;
        logic               joint_fresh;
        logic               joint_match;
        logic               enable_update;
        logic               enable_value;
    } sample_t;

    typedef struct packed {
        logic signed [20:0] velocity;
        fault_t             fault;
        logic               limited;
    } vel_cmd_t;

endpackage

// ----- hw/rtl/pd_grasp_velocity_controller.sv -----
// ----------------------------------------------------------------------------
// pd_grasp_velocity_controller
// PD contact-area controller with velocity clamp, sample faults and joint limits.
// ----------------------------------------------------------------------------
// The sample stage registers an accepted sample, and the command register loads
// from it when the item advances; vel_cmd is driven from the command register.
// Throughput: one sample per cycle; the PD multiply and clamp take one stage, and
// a stalled command holds the sample stage and then the input.
// The held samples and the enable flag update at acceptance, the stored error
// when the item moves into the result register.
// Reset clears the held state and loads the register defaults.
// ----------------------------------------------------------------------------
module pd_grasp_velocity_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  pdgv_pkg::sample_t         sample,
    output logic                      vel_valid,
    input  logic                      vel_ready,
    output pdgv_pkg::vel_cmd_t        vel_cmd,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [23:0]               cfg_data
);

    logic [15:0]        contact_setpoint_reg;
    logic [23:0]        prop_gain_reg;
    logic [23:0]        deriv_gain_reg;
    logic [19:0]        velocity_limit_reg;
    logic signed [15:0] upper_joint_limit_reg;
    logic signed [15:0] lower_joint_limit_reg;

    logic signed [16:0] prev_err_reg;
    logic signed [16:0] prev_err_next;
    logic [15:0]        held_contact_reg;
    logic signed [15:0] held_joint_reg;
    logic               grasp_enable_reg;

    logic               stage_valid_reg;
    logic               contact_fresh_reg;
    logic               joint_fresh_reg;

    logic               res_valid_reg;
    pdgv_pkg::vel_cmd_t res_reg;
    pdgv_pkg::vel_cmd_t res_next;

    logic               advance;
    logic               accept;

    logic signed [16:0] err;
    logic signed [17:0] diff;
    logic signed [41:0] prop_term;
    logic signed [42:0] deriv_term;
    logic signed [43:0] acc;
    logic signed [31:0] pd;
    logic signed [31:0] vmax;
    logic signed [20:0] vel_pd;
    logic signed [20:0] vel_sel;
    logic signed [20:0] vel_fault;

    assign cfg_ready    = 1'b1;
    assign advance      = stage_valid_reg && (!res_valid_reg || vel_ready);
    assign sample_ready = !stage_valid_reg || advance;
    assign accept       = sample_valid && sample_ready;
    assign vel_valid    = res_valid_reg;
    assign vel_cmd      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_setpoint_reg  <= pdgv_pkg::RST_CONTACT_SETPOINT;
            prop_gain_reg         <= pdgv_pkg::RST_PROP_GAIN;
            deriv_gain_reg        <= pdgv_pkg::RST_DERIV_GAIN;
            velocity_limit_reg    <= pdgv_pkg::RST_VELOCITY_LIMIT;
            upper_joint_limit_reg <= pdgv_pkg::RST_UPPER_JOINT_LIMIT;
            lower_joint_limit_reg <= pdgv_pkg::RST_LOWER_JOINT_LIMIT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pdgv_pkg::CFG_CONTACT_SETPOINT:  contact_setpoint_reg  <= cfg_data[15:0];
                pdgv_pkg::CFG_PROP_GAIN:         prop_gain_reg         <= cfg_data;
                pdgv_pkg::CFG_DERIV_GAIN:        deriv_gain_reg        <= cfg_data;
                pdgv_pkg::CFG_VELOCITY_LIMIT:    velocity_limit_reg    <= cfg_data[19:0];
                pdgv_pkg::CFG_UPPER_JOINT_LIMIT: upper_joint_limit_reg <= $signed(cfg_data[15:0]);
                pdgv_pkg::CFG_LOWER_JOINT_LIMIT: lower_joint_limit_reg <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // Held samples and the enable flag take effect as the item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_contact_reg  <= '0;
            held_joint_reg    <= '0;
            grasp_enable_reg  <= 1'b0;
            stage_valid_reg   <= 1'b0;
            contact_fresh_reg <= 1'b0;
            joint_fresh_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (sample.enable_update)
                begin
                    grasp_enable_reg <= sample.enable_value;
                end
                if (sample.contact_fresh)
                begin
                    held_contact_reg <= sample.touch_area & pdgv_pkg::CONTACT_MASK;
                end
                if (sample.joint_fresh && sample.joint_match)
                begin
                    held_joint_reg <= sample.joint_position;
                end
                contact_fresh_reg <= sample.contact_fresh;
                joint_fresh_reg   <= sample.joint_fresh;
                stage_valid_reg   <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        err        = $signed({1'b0, contact_setpoint_reg}) - $signed({1'b0, held_contact_reg});
        diff       = $signed({err[16], err}) - $signed({prev_err_reg[16], prev_err_reg});
        prop_term  = $signed({18'b0, prop_gain_reg}) * $signed({{25{err[16]}}, err});
        deriv_term = $signed({19'b0, deriv_gain_reg}) * $signed({{25{diff[17]}}, diff});
        acc        = $signed({{2{prop_term[41]}}, prop_term})
                   + $signed({deriv_term[42], deriv_term});
        pd         = acc[43:12];
        vmax       = $signed({12'b0, velocity_limit_reg});

        if (pd > vmax)
        begin
            vel_pd = vmax[20:0];
        end
        else if (pd < -vmax)
        begin
            vel_pd = 21'(-vmax);
        end
        else
        begin
            vel_pd = pd[20:0];
        end

        if (grasp_enable_reg)
        begin
            vel_sel       = vel_pd;
            prev_err_next = err;
        end
        else
        begin
            vel_sel       = -$signed({1'b0, velocity_limit_reg});
            prev_err_next = prev_err_reg;
        end

        if (!joint_fresh_reg)
        begin
            vel_fault      = '0;
            res_next.fault = pdgv_pkg::FAULT_JOINT;
        end
        else if (!contact_fresh_reg)
        begin
            vel_fault      = '0;
            res_next.fault = pdgv_pkg::FAULT_CONTACT;
        end
        else
        begin
            vel_fault      = vel_sel;
            res_next.fault = pdgv_pkg::FAULT_NONE;
        end

        res_next.velocity = vel_fault;
        res_next.limited  = 1'b0;
        if (held_joint_reg >= upper_joint_limit_reg)
        begin
            if (vel_fault > 21'sd0)
            begin
                res_next.velocity = '0;
                res_next.limited  = 1'b1;
            end
        end
        else if (held_joint_reg <= lower_joint_limit_reg)
        begin
            if (vel_fault < 21'sd0)
            begin
                res_next.velocity = '0;
                res_next.limited  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_err_reg  <= prev_err_next;
            res_valid_reg <= 1'b1;
        end
        else if (vel_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // A fault or a limit hit always leaves a zero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.fault != pdgv_pkg::FAULT_NONE) |-> res_reg.velocity == '0)
        else $error("faulted result with nonzero velocity");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.limited |-> res_reg.velocity == '0)
        else $error("limited result with nonzero velocity");

    // The stored error only moves while grasping is enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !grasp_enable_reg |=> $stable(prev_err_reg))
        else $error("previous error changed while disabled");

    // A new result only appears after an item sat in the compute stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(stage_valid_reg))
        else $error("result appeared without a staged item");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.fault <= pdgv_pkg::FAULT_CONTACT)
        else $error("undefined fault code");

endmodule
